// ===== design/gcr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcr_pkg
// Shared types and constants of the gradient colour ramp: item and result
// layouts, operation and status codes, controller states, command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gcr_pkg;

    localparam int P_MAX_STOPS     = 16;
    localparam int P_MAX_RAMP      = 4096;
    localparam int P_POS_FRAC_BITS = 16;

    localparam int P_POS_W   = P_POS_FRAC_BITS + 1;
    localparam int P_COLOR_W = 32;
    localparam int P_IDX_W   = 12;
    localparam int P_LEN_W   = 13;
    localparam int P_CFG_W   = 32;
    localparam int P_CH_W    = 8;
    localparam int P_NUM_CH  = P_COLOR_W / P_CH_W;
    localparam int P_NUM_W   = P_IDX_W + P_CH_W;
    localparam int P_ENTRY_W = P_POS_W + P_COLOR_W;

    localparam logic [P_POS_W-1:0] P_POS_ONE      = P_POS_W'(1) << P_POS_FRAC_BITS;
    localparam logic [P_LEN_W-1:0] P_LEN_RESET    = P_LEN_W'(2048);

    // operation codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_EVAL   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_OOB  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_START_COLOR = 2'd0;
    localparam logic [1:0] CFG_END_COLOR   = 2'd1;
    localparam logic [1:0] CFG_RAMP_LENGTH = 2'd2;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [P_POS_W-1:0]   stop_position;
        logic [P_COLOR_W-1:0] stop_color_word;
        logic [P_IDX_W-1:0]   ramp_index;
    } t_item;

    typedef struct packed {
        logic [P_COLOR_W-1:0] out_color;
        logic [1:0]           status;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_TEST,
        S_INS_CMP,
        S_EV_RD,
        S_EV_MUL,
        S_EV_CMP,
        S_NUM,
        S_DIV,
        S_RES
    } t_state;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_ZERO_OK,
        RES_FULL,
        RES_OOB,
        RES_END,
        RES_BLEND
    } t_res_sel;

    typedef struct packed {
        logic     load;
        t_res_sel res_sel;
        logic     clr_count;
        logic     ins_init;
        logic     ins_rd;
        logic     ins_shift;
        logic     ins_new;
        logic     ev_init;
        logic     ev_rd;
        logic     ev_mul;
        logic     ev_adv;
        logic     seg_stop;
        logic     seg_end;
        logic     num;
        logic     div_step;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       oob;
        logic       last;
        logic       ptr_zero;
        logic       ptr_at_count;
        logic       pos_below;
        logic       h_above_k;
        logic       div_last;
    } t_sts;

endpackage
`default_nettype wire

// ===== design/gcr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module gcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== design/gcr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcr_ctrl
// Sequencer of the colour ramp: dispatches each item, walks the stop table
// for insert and evaluate, and drives the per-channel division steps.
// ----------------------------------------------------------------------------
module gcr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output logic               o_busy,
    output gcr_pkg::t_cmd      o_cmd,
    input  wire gcr_pkg::t_sts i_sts
);
    import gcr_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.res_sel = RES_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.op)
                    OP_CLEAR: begin
                        cmd.clr_count = 1'b1;
                        cmd.res_sel   = RES_ZERO_OK;
                        n_state       = S_IDLE;
                    end
                    OP_INSERT: begin
                        if (i_sts.full) begin
                            cmd.res_sel = RES_FULL;
                            n_state     = S_IDLE;
                        end else begin
                            cmd.ins_init = 1'b1;
                            n_state      = S_INS_TEST;
                        end
                    end
                    OP_EVAL: begin
                        if (i_sts.oob) begin
                            cmd.res_sel = RES_OOB;
                            n_state     = S_IDLE;
                        end else if (i_sts.last) begin
                            cmd.res_sel = RES_END;
                            n_state     = S_IDLE;
                        end else begin
                            cmd.ev_init = 1'b1;
                            n_state     = S_EV_RD;
                        end
                    end
                    default: begin
                        cmd.res_sel = RES_ZERO_OK;
                        n_state     = S_IDLE;
                    end
                endcase
            end
            // walk down from the top, moving up every stop not below the new one
            S_INS_TEST: begin
                if (i_sts.ptr_zero) begin
                    cmd.ins_new = 1'b1;
                    cmd.res_sel = RES_ZERO_OK;
                    n_state     = S_IDLE;
                end else begin
                    cmd.ins_rd = 1'b1;
                    n_state    = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_sts.pos_below) begin
                    cmd.ins_new = 1'b1;
                    cmd.res_sel = RES_ZERO_OK;
                    n_state     = S_IDLE;
                end else begin
                    cmd.ins_shift = 1'b1;
                    n_state       = S_INS_TEST;
                end
            end
            S_EV_RD: begin
                if (i_sts.ptr_at_count) begin
                    cmd.seg_end = 1'b1;
                    n_state     = S_NUM;
                end else begin
                    cmd.ev_rd = 1'b1;
                    n_state   = S_EV_MUL;
                end
            end
            S_EV_MUL: begin
                cmd.ev_mul = 1'b1;
                n_state    = S_EV_CMP;
            end
            S_EV_CMP: begin
                if (i_sts.h_above_k) begin
                    cmd.seg_stop = 1'b1;
                    n_state      = S_NUM;
                end else begin
                    cmd.ev_adv = 1'b1;
                    n_state    = S_EV_RD;
                end
            end
            S_NUM: begin
                cmd.num = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                cmd.res_sel = RES_BLEND;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ===== design/gcr_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcr_dpath
// Datapath of the colour ramp: configuration registers, item registers,
// stop table memory, segment boundary multiply, four channel dividers and
// the result register.
// ----------------------------------------------------------------------------
module gcr_dpath #(
    parameter int MAX_STOPS = gcr_pkg::P_MAX_STOPS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [1:0]              i_cfg_idx,
    input  wire logic [gcr_pkg::P_CFG_W-1:0] i_cfg_data,
    input  wire gcr_pkg::t_item          i_item,
    input  wire gcr_pkg::t_cmd           i_cmd,
    output gcr_pkg::t_sts                o_sts,
    output logic                         o_done,
    output gcr_pkg::t_result             o_result
);
    import gcr_pkg::*;

    localparam int CW = $clog2(MAX_STOPS + 1);
    localparam int AW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int PW = P_POS_W + P_IDX_W;

    // configuration
    logic [P_COLOR_W-1:0] r_start_color;
    logic [P_COLOR_W-1:0] r_end_color;
    logic [P_LEN_W-1:0]   r_ramp_len;

    // item
    logic [1:0]           r_op;
    logic [P_POS_W-1:0]   r_pos;
    logic [P_COLOR_W-1:0] r_color;
    logic [P_IDX_W-1:0]   r_k;
    logic [P_IDX_W-1:0]   r_cxm1;
    logic                 r_oob;
    logic                 r_last;

    // table walk
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_ptr;
    logic [P_IDX_W-1:0]   r_l;
    logic [P_COLOR_W-1:0] r_cl;
    logic [P_IDX_W-1:0]   r_h;
    logic [P_COLOR_W-1:0] r_sc;

    // segment and dividers
    logic [P_IDX_W-1:0]   r_w;
    logic [P_IDX_W-1:0]   r_j;
    logic [P_COLOR_W-1:0] r_c0;
    logic [P_COLOR_W-1:0] r_c1;
    logic [P_IDX_W-1:0]   r_rem [P_NUM_CH];
    logic [P_CH_W-1:0]    r_q   [P_NUM_CH];
    logic [2:0]           r_div_cnt;

    logic                 r_done;
    t_result              r_res;

    // combinational
    logic [P_LEN_W-1:0]   cx;
    logic [P_LEN_W-1:0]   cxm1_full;
    logic [P_POS_W-1:0]   pos_clamped;
    logic [CW-1:0]        ptr_m1;
    logic [P_ENTRY_W-1:0] rd_entry;
    logic [P_POS_W-1:0]   rd_pos;
    logic [P_COLOR_W-1:0] rd_color;
    logic [PW-1:0]        bound_prod;
    logic                 ram_we;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [P_ENTRY_W-1:0] ram_wdata;
    logic [P_NUM_W-1:0]   num     [P_NUM_CH];
    logic [P_IDX_W:0]     trial   [P_NUM_CH];
    logic                 ge      [P_NUM_CH];
    logic [P_COLOR_W-1:0] blend_color;
    logic [P_IDX_W-1:0]   wmj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_color <= '0;
            r_end_color   <= '0;
            r_ramp_len    <= P_LEN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_COLOR: r_start_color <= i_cfg_data;
                CFG_END_COLOR:   r_end_color   <= i_cfg_data;
                CFG_RAMP_LENGTH: r_ramp_len    <= i_cfg_data[P_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective ramp length and clamped position
    always_comb begin
        if (r_ramp_len == '0) begin
            cx = P_LEN_W'(1);
        end else if (r_ramp_len > P_LEN_W'(P_MAX_RAMP)) begin
            cx = P_LEN_W'(P_MAX_RAMP);
        end else begin
            cx = r_ramp_len;
        end
        cxm1_full = cx - P_LEN_W'(1);
        if (i_item.stop_position > P_POS_ONE) begin
            pos_clamped = P_POS_ONE;
        end else begin
            pos_clamped = i_item.stop_position;
        end
    end

    assign ptr_m1    = r_ptr - CW'(1);
    assign rd_pos    = rd_entry[P_ENTRY_W-1 -: P_POS_W];
    assign rd_color  = rd_entry[P_COLOR_W-1:0];
    assign ram_we    = i_cmd.ins_shift | i_cmd.ins_new;
    assign ram_re    = i_cmd.ins_rd | i_cmd.ev_rd;
    assign ram_raddr = i_cmd.ins_rd ? ptr_m1[AW-1:0] : r_ptr[AW-1:0];
    assign ram_wdata = i_cmd.ins_shift ? rd_entry : {r_pos, r_color};
    assign bound_prod = PW'(rd_pos) * PW'(r_cxm1);

    gcr_ram #(
        .WIDTH (P_ENTRY_W),
        .DEPTH (MAX_STOPS)
    ) u_stops (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ptr[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd_entry)
    );

    // per-channel numerator and restoring division step
    always_comb begin
        wmj = r_w - r_j;
        for (int ch = 0; ch < P_NUM_CH; ch++) begin
            num[ch] = P_NUM_W'(wmj) * P_NUM_W'(r_c0[ch*P_CH_W +: P_CH_W])
                    + P_NUM_W'(r_j) * P_NUM_W'(r_c1[ch*P_CH_W +: P_CH_W]);
            trial[ch] = {r_rem[ch], r_q[ch][P_CH_W-1]};
            ge[ch]    = (trial[ch] >= {1'b0, r_w});
            blend_color[ch*P_CH_W +: P_CH_W] = r_q[ch];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ptr     <= '0;
            r_div_cnt <= '0;
            r_done    <= 1'b0;
        end else begin
            r_done <= (i_cmd.res_sel != RES_NONE);
            if (i_cmd.clr_count) begin
                r_count <= '0;
            end else if (i_cmd.ins_new) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.ins_init) begin
                r_ptr <= r_count;
            end else if (i_cmd.ins_shift) begin
                r_ptr <= ptr_m1;
            end else if (i_cmd.ev_init) begin
                r_ptr <= '0;
            end else if (i_cmd.ev_adv) begin
                r_ptr <= r_ptr + CW'(1);
            end
            if (i_cmd.num) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 3'd1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_item.opcode;
            r_pos   <= pos_clamped;
            r_color <= i_item.stop_color_word;
            r_k     <= i_item.ramp_index;
            r_cxm1  <= cxm1_full[P_IDX_W-1:0];
            r_oob   <= ({1'b0, i_item.ramp_index} >= cx);
            r_last  <= (i_item.ramp_index == cxm1_full[P_IDX_W-1:0]);
        end
        if (i_cmd.ev_init) begin
            r_l  <= '0;
            r_cl <= r_start_color;
        end else if (i_cmd.ev_adv) begin
            r_l  <= r_h;
            r_cl <= r_sc;
        end
        if (i_cmd.ev_mul) begin
            r_h  <= bound_prod[P_POS_FRAC_BITS +: P_IDX_W];
            r_sc <= rd_color;
        end
        if (i_cmd.seg_stop) begin
            r_w  <= r_h - r_l;
            r_j  <= r_k - r_l;
            r_c0 <= r_cl;
            r_c1 <= r_sc;
        end else if (i_cmd.seg_end) begin
            r_w  <= r_cxm1 - r_l;
            r_j  <= r_k - r_l;
            r_c0 <= r_cl;
            r_c1 <= r_end_color;
        end
        for (int ch = 0; ch < P_NUM_CH; ch++) begin
            if (i_cmd.num) begin
                r_rem[ch] <= num[ch][P_NUM_W-1 -: P_IDX_W];
                r_q[ch]   <= num[ch][P_CH_W-1:0];
            end else if (i_cmd.div_step) begin
                r_rem[ch] <= ge[ch] ? P_IDX_W'(trial[ch] - {1'b0, r_w})
                                    : trial[ch][P_IDX_W-1:0];
                r_q[ch]   <= {r_q[ch][P_CH_W-2:0], ge[ch]};
            end
        end
        case (i_cmd.res_sel)
            RES_ZERO_OK: r_res <= '{out_color: '0, status: ST_OK};
            RES_FULL:    r_res <= '{out_color: '0, status: ST_FULL};
            RES_OOB:     r_res <= '{out_color: '0, status: ST_OOB};
            RES_END:     r_res <= '{out_color: r_end_color, status: ST_OK};
            RES_BLEND:   r_res <= '{out_color: blend_color, status: ST_OK};
            default: ;
        endcase
    end

    always_comb begin
        o_sts.op           = r_op;
        o_sts.full         = (r_count == CW'(MAX_STOPS));
        o_sts.oob          = r_oob;
        o_sts.last         = r_last;
        o_sts.ptr_zero     = (r_ptr == '0);
        o_sts.ptr_at_count = (r_ptr == r_count);
        o_sts.pos_below    = (rd_pos < r_pos);
        o_sts.h_above_k    = (r_h > r_k);
        o_sts.div_last     = (r_div_cnt == 3'd7);
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
`default_nettype wire

// ===== design/gradient_color_ramp_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gradient_color_ramp_top
// Sorted colour stop table with per-entry lookup into a multi-stop linear
// gradient ramp.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; exactly one result
// follows, shown on o_result for a single cycle while o_done is high, and it
// must be captured then, as the block cannot be held off. Clear, unused
// operations, a full table and an out-of-range index finish straight from
// dispatch. An insert walks down from the top of the table, each moved stop
// costing a read and then a write of the stop memory, until the bottom of
// the table or a stop below the new position ends the walk and the new stop
// is written. An evaluate at the last entry returns the end colour from
// dispatch; any other walks the stops (read, boundary multiply, compare per
// stop) until the segment is found, closed by a stop or by the end colour,
// and then forms eight quotient bits per channel in the four dividers
// running side by side.
// Busy falls in the cycle o_done rises, so the next item can follow at once.
// ----------------------------------------------------------------------------
module gradient_color_ramp_top #(
    parameter int MAX_STOPS = gcr_pkg::P_MAX_STOPS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire gcr_pkg::t_item              i_item,
    output logic                             o_done,
    output gcr_pkg::t_result                 o_result,
    input  wire logic                        i_cfg_we,
    input  wire logic [1:0]                  i_cfg_idx,
    input  wire logic [gcr_pkg::P_CFG_W-1:0] i_cfg_data
);
    import gcr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    gcr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    gcr_dpath #(
        .MAX_STOPS (MAX_STOPS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule
`default_nettype wire
